### design/gtm_pkg.sv
package gtm_pkg;

   // operand and accumulator geometry
   localparam int IN_WIDTH       = 16;
   localparam int ACC_WIDTH      = 48;
   localparam int PROD_WIDTH     = 2 * IN_WIDTH;
   localparam int TILE_DIM       = 4;
   localparam int ROW_WIDTH      = 2;
   localparam int REQ_DATA_WIDTH = 2 * TILE_DIM * IN_WIDTH;
   localparam int RSP_DATA_WIDTH = TILE_DIM * ACC_WIDTH;

   typedef logic signed [IN_WIDTH-1:0]   operand_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;
   typedef logic signed [ACC_WIDTH-1:0]  acc_type;
   typedef logic [ROW_WIDTH-1:0]         row_type;

   localparam acc_type ACC_MAX  = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam acc_type ACC_MIN  = {1'b1, {(ACC_WIDTH-1){1'b0}}};
   localparam row_type ROW_LAST = ROW_WIDTH'(TILE_DIM - 1);

   // control from the top level to each MAC cell
   typedef struct packed {
      logic load;    // capture a new product
      logic acc_en;  // fold the held product into the accumulator
      logic clear;   // the held product closes the tile
   } mac_ctl_type;

   // status of the result drain buffer
   typedef struct packed {
      logic    valid;  // a row is on the result channel
      logic    free;   // buffer can take a tile this cycle
      row_type row;    // row currently presented
   } out_status_type;

endpackage

### design/gtm_mac_cell.sv
module gtm_mac_cell import gtm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mac_ctl_type ctl,
   input  operand_type a_in,
   input  operand_type b_in,
   output acc_type     sum_next
);

   prod_type                 prod_ff;
   prod_type                 prod_in;
   acc_type                  acc_ff;
   acc_type                  acc_in;
   logic signed [ACC_WIDTH:0] wide_sum;

   // multiply stage
   assign prod_in = a_in * b_in;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         prod_ff <= prod_in;
      end
   end

   // saturating accumulate, one guard bit
   always_comb begin
      wide_sum = {acc_ff[ACC_WIDTH-1], acc_ff}
               + {{(ACC_WIDTH + 1 - PROD_WIDTH){prod_ff[PROD_WIDTH-1]}}, prod_ff};
      if (wide_sum[ACC_WIDTH] != wide_sum[ACC_WIDTH-1]) begin
         acc_in = wide_sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_in = wide_sum[ACC_WIDTH-1:0];
      end
   end

   assign sum_next = acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctl.acc_en) begin
         acc_ff <= ctl.clear ? '0 : acc_in;
      end
   end

endmodule

### design/gtm_out_buf.sv
module gtm_out_buf import gtm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  acc_type        tile_sums [TILE_DIM][TILE_DIM],
   input  logic           rsp_tready,
   output acc_type        row_sums [TILE_DIM],
   output out_status_type status
);

   acc_type rows_ff [TILE_DIM][TILE_DIM];
   logic    valid_ff;
   row_type row_ff;
   logic    advance;
   logic    done;

   assign advance = valid_ff && rsp_tready;
   assign done    = advance && (row_ff == ROW_LAST);

   assign status.valid = valid_ff;
   assign status.free  = !valid_ff || done;
   assign status.row   = row_ff;

   // row 0 slot always holds the row on the channel
   always_comb begin
      for (int c = 0; c < TILE_DIM; c++) begin
         row_sums[c] = rows_ff[0][c];
      end
   end

   // tile snapshot, then shift one row per transfer
   always_ff @(posedge clock) begin
      if (load) begin
         rows_ff <= tile_sums;
      end else if (advance) begin
         for (int r = 0; r < TILE_DIM - 1; r++) begin
            rows_ff[r] <= rows_ff[r+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         row_ff   <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         row_ff   <= '0;
      end else if (advance) begin
         if (row_ff == ROW_LAST) begin
            valid_ff <= 1'b0;
         end
         row_ff <= row_ff + 1'b1;
      end
   end

endmodule

### design/gemm_tile4x4_outer_product_mac.sv
// channel | dir | tdata (low bit first)                     | tuser    | tlast
// req_    | in  | a_row0..a_row3, b_col0..b_col3 (16b each) | -        | last_step
// rsp_    | out | sum_col0..sum_col3 (48b each)             | tile_row | last_row
//
// One reduction step per cycle unless the input stalls: each step is held in the product
// register and the saturated sums load the drain buffer directly, so the first row of a
// tile is presented from the drain buffer once its last step has passed the product
// register; the four rows then leave one per cycle while rsp_tready is high. Reset
// clears the accumulators and empties both stages. The input stalls only while a step
// marked last waits for the drain buffer, which frees with the fourth row transfer;
// with rsp_tready held high, tiles of four steps or more run at full rate.
module gemm_tile4x4_outer_product_mac import gtm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,   // a_row0..3, b_col0..3
   input  logic                      req_tlast,   // last_step
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,   // sum_col0..3
   output logic [ROW_WIDTH-1:0]      rsp_tuser,   // tile_row
   output logic                      rsp_tlast    // last_row
);

   logic           prod_valid_ff;
   logic           prod_last_ff;
   logic           prod_take;
   logic           advance;
   logic           buf_load;
   mac_ctl_type    mac_ctl;
   out_status_type status;
   acc_type        tile_sums [TILE_DIM][TILE_DIM];
   acc_type        row_sums [TILE_DIM];

   // product stage control; only a closing step waits on the drain buffer
   assign prod_take  = !prod_last_ff || status.free;
   assign advance    = !prod_valid_ff || prod_take;
   assign req_tready = advance;
   assign buf_load   = prod_valid_ff && prod_last_ff && status.free;

   assign mac_ctl.load   = req_tvalid && advance;
   assign mac_ctl.acc_en = prod_valid_ff && prod_take;
   assign mac_ctl.clear  = prod_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         prod_last_ff  <= 1'b0;
      end else if (advance) begin
         prod_valid_ff <= req_tvalid;
         prod_last_ff  <= req_tlast;
      end
   end

   // 4x4 grid of MAC cells
   for (genvar r = 0; r < TILE_DIM; r++) begin : g_row
      for (genvar c = 0; c < TILE_DIM; c++) begin : g_col
         gtm_mac_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (mac_ctl),
            .a_in     (req_tdata[r*IN_WIDTH +: IN_WIDTH]),
            .b_in     (req_tdata[(TILE_DIM+c)*IN_WIDTH +: IN_WIDTH]),
            .sum_next (tile_sums[r][c])
         );
      end
   end

   gtm_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (buf_load),
      .tile_sums  (tile_sums),
      .rsp_tready (rsp_tready),
      .row_sums   (row_sums),
      .status     (status)
   );

   // result channel
   for (genvar c = 0; c < TILE_DIM; c++) begin : g_out
      assign rsp_tdata[c*ACC_WIDTH +: ACC_WIDTH] = row_sums[c];
   end

   assign rsp_tvalid = status.valid;
   assign rsp_tuser  = status.row;
   assign rsp_tlast  = (status.row == ROW_LAST);

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result channel valid right after reset");

   a_rows_in_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tuser == ROW_WIDTH'($past(rsp_tuser) + 1'b1)))
      else $error("tile rows not delivered back to back in order");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && prod_valid_ff && prod_last_ff)
      else $error("input stalled without a pending tile");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      buf_load |-> !rsp_tvalid || (rsp_tready && rsp_tlast))
      else $error("drain buffer loaded while rows still pending");

   a_load_starts_row0: assert property (@(posedge clock) disable iff (reset)
      buf_load |=> rsp_tvalid && (rsp_tuser == '0))
      else $error("new tile does not start at row zero");
`endif

endmodule
